/* src/rts_pkg.sv */
// ----------------------------------------------------------------------------
// rts_pkg
// Types and constants shared by the Robinson triangle subdivision block.
// ----------------------------------------------------------------------------
package rts_pkg;

  // Coordinate width, Q10.14 two's complement
  localparam int unsigned CoordW = 24;
  // 1/phi in Q0.16, 0.6180
  localparam int unsigned InvPhiQ16 = 40503;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [CoordW:0]   diff_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef struct packed {
    logic   in_color;
    coord_t in_ax;
    coord_t in_ay;
    coord_t in_bx;
    coord_t in_by;
    coord_t in_cx;
    coord_t in_cy;
  } tri_in_t;

  typedef struct packed {
    logic   out_color;
    coord_t out_ax;
    coord_t out_ay;
    coord_t out_bx;
    coord_t out_by;
    coord_t out_cx;
    coord_t out_cy;
    logic   last_of_run;
  } tri_out_t;

  // Rule set and input colour together: {tiling_mode, in_color}
  typedef enum logic [1:0] {
    KIND_M0_RED  = 2'b00,
    KIND_M0_BLUE = 2'b01,
    KIND_M1_RED  = 2'b10,
    KIND_M1_BLUE = 2'b11
  } kind_e;

  localparam logic ColorRed  = 1'b0;
  localparam logic ColorBlue = 1'b1;

  // Triangle with its two new points, as handed to the emitter
  typedef struct packed {
    kind_e  kind;
    point_t a;
    point_t b;
    point_t c;
    point_t p0;
    point_t p1;
  } split_t;

endpackage

/* src/robinson_triangle_subdivide.sv */
// ----------------------------------------------------------------------------
// robinson_triangle_subdivide
// One level of Robinson triangle subdivision for Penrose tilings.
// ----------------------------------------------------------------------------
// A triangle is taken when start is high and busy is low. Its two or three
// children appear on result_o, one per cycle with result_strobe_o high, the
// last flagged by last_of_run; with the block idle the first child goes from
// the input register through the emitter's hold register to the result
// register. The receiver cannot stall, so a triangle with three children
// holds the result port longer than one with two, and the single result port
// sets the sustained rate. A waiting triangle is held in the input register
// meanwhile, and busy is high only while that register cannot be freed.
// tiling_mode is written through the cfg channel, which is always ready;
// write it only with no triangle in flight.
// ----------------------------------------------------------------------------
module robinson_triangle_subdivide (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  rts_pkg::tri_in_t  tri_i,
  output logic              result_strobe_o,
  output rts_pkg::tri_out_t result_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_data_i
);

  localparam int unsigned W = rts_pkg::CoordW;

  typedef struct packed {
    rts_pkg::kind_e  kind;
    rts_pkg::point_t a;
    rts_pkg::point_t b;
    rts_pkg::point_t c;
    rts_pkg::diff_t  d0x;
    rts_pkg::diff_t  d0y;
    rts_pkg::diff_t  d1x;
    rts_pkg::diff_t  d1y;
  } stage_t;

  logic            mode_q;
  logic            s1_valid_q, s1_valid_d;
  stage_t          s1_q, s1_d;
  logic            accept;
  logic            load;
  logic            take;
  rts_pkg::point_t v0, w0;
  rts_pkg::point_t p0, p1;
  rts_pkg::point_t v0_s;
  rts_pkg::split_t split;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= cfg_data_i;
    end
  end

  assign load   = s1_valid_q && take;
  assign busy   = s1_valid_q && !take;
  assign accept = start && !busy;

  // First new point's end points by rule; the second is always b toward c
  always_comb begin
    s1_d.kind = rts_pkg::kind_e'({mode_q, tri_i.in_color});
    s1_d.a    = '{x: tri_i.in_ax, y: tri_i.in_ay};
    s1_d.b    = '{x: tri_i.in_bx, y: tri_i.in_by};
    s1_d.c    = '{x: tri_i.in_cx, y: tri_i.in_cy};
    unique case (s1_d.kind)
      rts_pkg::KIND_M0_BLUE: begin
        v0 = s1_d.b;
        w0 = s1_d.a;
      end
      rts_pkg::KIND_M1_BLUE: begin
        v0 = s1_d.c;
        w0 = s1_d.a;
      end
      default: begin
        v0 = s1_d.a;
        w0 = s1_d.b;
      end
    endcase
    s1_d.d0x = {w0.x[W-1], w0.x} - {v0.x[W-1], v0.x};
    s1_d.d0y = {w0.y[W-1], w0.y} - {v0.y[W-1], v0.y};
    s1_d.d1x = {s1_d.c.x[W-1], s1_d.c.x} - {s1_d.b.x[W-1], s1_d.b.x};
    s1_d.d1y = {s1_d.c.y[W-1], s1_d.c.y} - {s1_d.b.y[W-1], s1_d.b.y};
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (load) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
  end

  always_comb begin
    unique case (s1_q.kind)
      rts_pkg::KIND_M0_BLUE: v0_s = s1_q.b;
      rts_pkg::KIND_M1_BLUE: v0_s = s1_q.c;
      default:               v0_s = s1_q.a;
    endcase
  end

  rts_lerp u_p0x (.v_i(v0_s.x),   .d_i(s1_q.d0x), .p_o(p0.x));
  rts_lerp u_p0y (.v_i(v0_s.y),   .d_i(s1_q.d0y), .p_o(p0.y));
  rts_lerp u_p1x (.v_i(s1_q.b.x), .d_i(s1_q.d1x), .p_o(p1.x));
  rts_lerp u_p1y (.v_i(s1_q.b.y), .d_i(s1_q.d1y), .p_o(p1.y));

  always_comb begin
    split.kind = s1_q.kind;
    split.a    = s1_q.a;
    split.b    = s1_q.b;
    split.c    = s1_q.c;
    split.p0   = p0;
    split.p1   = p1;
  end

  rts_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .split_i     (split),
    .take_o      (take),
    .res_valid_o (result_strobe_o),
    .res_o       (result_o)
  );

endmodule

/* src/rts_lerp.sv */
// ----------------------------------------------------------------------------
// rts_lerp
// One new coordinate: v + round(d * 1/phi), saturated to the coordinate range.
// ----------------------------------------------------------------------------
module rts_lerp (
  input  rts_pkg::coord_t v_i,
  input  rts_pkg::diff_t  d_i,
  output rts_pkg::coord_t p_o
);

  localparam int unsigned W    = rts_pkg::CoordW;
  localparam int unsigned KW   = 17;
  localparam int unsigned PW   = W + 1 + KW;
  localparam int unsigned QW   = PW - 16;

  logic [KW-1:0]        k;
  logic [PW-1:0]        prod;
  logic [PW-1:0]        rnd;
  logic signed [QW-1:0] q;
  logic signed [QW-1:0] sum;
  logic                 ovf;

  assign k    = KW'(rts_pkg::InvPhiQ16);
  assign prod = {{KW{d_i[W]}}, d_i} * {{(PW-KW){1'b0}}, k};
  // round half up, then drop the fraction
  assign rnd  = prod + PW'(32768);
  assign q    = $signed(rnd[PW-1:16]);
  assign sum  = $signed({{(QW-W){v_i[W-1]}}, v_i}) + q;

  // top three bits must agree for the sum to fit
  assign ovf = (sum[QW-1:W-1] != {(QW-W+1){1'b0}}) &&
               (sum[QW-1:W-1] != {(QW-W+1){1'b1}});

  always_comb begin
    if (!ovf) begin
      p_o = sum[W-1:0];
    end else if (sum[QW-1]) begin
      p_o = {1'b1, {(W-1){1'b0}}};
    end else begin
      p_o = {1'b0, {(W-1){1'b1}}};
    end
  end

endmodule

/* src/rts_emit.sv */
// ----------------------------------------------------------------------------
// rts_emit
// Holds one split triangle and issues its children, one per cycle, into the
// result register.
// ----------------------------------------------------------------------------
module rts_emit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  rts_pkg::split_t   split_i,
  output logic              take_o,
  output logic              res_valid_o,
  output rts_pkg::tri_out_t res_o
);

  logic              valid_q, valid_d;
  logic [1:0]        idx_q, idx_d;
  rts_pkg::split_t   split_q;
  logic              last;
  logic              res_valid_q;
  rts_pkg::tri_out_t res_q, res_d;

  function automatic rts_pkg::tri_out_t mk(
    input logic            color,
    input rts_pkg::point_t a,
    input rts_pkg::point_t b,
    input rts_pkg::point_t c,
    input logic            lst
  );
    rts_pkg::tri_out_t t;
    t.out_color   = color;
    t.out_ax      = a.x;
    t.out_ay      = a.y;
    t.out_bx      = b.x;
    t.out_by      = b.y;
    t.out_cx      = c.x;
    t.out_cy      = c.y;
    t.last_of_run = lst;
    return t;
  endfunction

  always_comb begin
    case (split_q.kind)
      rts_pkg::KIND_M0_RED, rts_pkg::KIND_M1_BLUE: last = (idx_q == 2'd1);
      default:                                     last = (idx_q == 2'd2);
    endcase
  end

  assign take_o = !valid_q || last;

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load_i) begin
      valid_d = 1'b1;
      idx_d   = '0;
    end else if (valid_q && last) begin
      valid_d = 1'b0;
    end else if (valid_q) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_comb begin
    res_d = '0;
    unique case (split_q.kind)
      rts_pkg::KIND_M0_RED: begin
        if (idx_q == 2'd0) begin
          res_d = mk(rts_pkg::ColorRed, split_q.c, split_q.p0, split_q.b, last);
        end else begin
          res_d = mk(rts_pkg::ColorBlue, split_q.p0, split_q.c, split_q.a, last);
        end
      end
      rts_pkg::KIND_M0_BLUE: begin
        if (idx_q == 2'd0) begin
          res_d = mk(rts_pkg::ColorBlue, split_q.p1, split_q.c, split_q.a, last);
        end else if (idx_q == 2'd1) begin
          res_d = mk(rts_pkg::ColorBlue, split_q.p0, split_q.p1, split_q.b, last);
        end else begin
          res_d = mk(rts_pkg::ColorRed, split_q.p1, split_q.p0, split_q.a, last);
        end
      end
      rts_pkg::KIND_M1_RED: begin
        if (idx_q == 2'd0) begin
          res_d = mk(rts_pkg::ColorBlue, split_q.p1, split_q.p0, split_q.b, last);
        end else if (idx_q == 2'd1) begin
          res_d = mk(rts_pkg::ColorRed, split_q.p0, split_q.a, split_q.p1, last);
        end else begin
          res_d = mk(rts_pkg::ColorRed, split_q.c, split_q.a, split_q.p1, last);
        end
      end
      rts_pkg::KIND_M1_BLUE: begin
        if (idx_q == 2'd0) begin
          res_d = mk(rts_pkg::ColorBlue, split_q.b, split_q.p0, split_q.a, last);
        end else begin
          res_d = mk(rts_pkg::ColorRed, split_q.p0, split_q.c, split_q.b, last);
        end
      end
      default: res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      idx_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      idx_q       <= idx_d;
      res_valid_q <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      split_q <= split_i;
    end
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

/* src/rts_checker.sv */
// ----------------------------------------------------------------------------
// rts_checker
// Port-level checks on result runs and the busy signal of the subdivider.
// ----------------------------------------------------------------------------
module rts_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_i,
  input logic              result_strobe_i,
  input rts_pkg::tri_out_t result_i
);

  // a run, once begun, continues every cycle until its last child
  a_run_unbroken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_i && !result_i.last_of_run |=> result_strobe_i)
    else $error("result run broken before its last child");

  // no run is longer than three children
  a_run_max_three: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_i && !result_i.last_of_run &&
    $past(result_strobe_i) && !$past(result_i.last_of_run)
    |=> result_strobe_i && result_i.last_of_run)
    else $error("result run longer than three children");

  // busy ends at the emitter's last child: the held triangle then moves on
  a_busy_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_i && $past(busy_i) |=> !busy_i)
    else $error("busy held for more than two cycles");

  // busy only follows a transfer or a held triangle
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_i && !start_i |=> !busy_i)
    else $error("busy raised with nothing taken");

endmodule

bind robinson_triangle_subdivide rts_checker u_rts_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start),
  .busy_i          (busy),
  .result_strobe_i (result_strobe_o),
  .result_i        (result_o)
);
